// ===== design/iag_pkg.sv =====
// Package for the im2col address generator: configuration register layout,
// item kinds, queue sizing and the back-end state type.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none

package iag_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned DIM_CFG_W   = 13;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_HEIGHT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATCH_SIZE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_SIZE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_STEP = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_AMOUNT  = 3'd6;

   // Register reset values.
   localparam logic [12:0] RST_IN_HEIGHT   = 13'd8;
   localparam logic [12:0] RST_IN_WIDTH    = 13'd8;
   localparam logic [12:0] RST_CHANNELS    = 13'd1;
   localparam logic [8:0]  RST_BATCH_SIZE  = 9'd1;
   localparam logic [3:0]  RST_KERNEL_SIZE = 4'd3;
   localparam logic [3:0]  RST_STRIDE_STEP = 4'd1;
   localparam logic [2:0]  RST_PAD_AMOUNT  = 3'd0;

   // Largest batch the walk supports.
   localparam logic [8:0] BATCH_MAX = 9'd256;

   // Depth of the queue between front and back; a power of two.
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [12:0] in_height;
      logic [12:0] in_width;
      logic [12:0] channels;
      logic [8:0]  batch_size;
      logic [3:0]  kernel_size;
      logic [3:0]  stride_step;
      logic [2:0]  pad_amount;
   } cfg_type;

   // What an accepted item asks of the walk.
   typedef enum logic [0:0] {
      KIND_ADVANCE = 1'b0,
      KIND_RESTART = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic          valid;
      item_kind_type kind;
   } push_type;

   // Back-end sequencer: one walk step, then three multiply-add passes.
   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_ROW  = 2'd1,
      BK_COL  = 2'd2,
      BK_CHAN = 2'd3
   } back_state_type;

endpackage

`default_nettype wire

// ===== design/iag_front.sv =====
// Front end of the im2col address generator: takes request items into an
// input register, classifies them and pushes them into the queue.
// Depends on iag_pkg.
`default_nettype none

module iag_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_restart,
   input  wire logic              q_full,
   output iag_pkg::push_type      push
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   iag_pkg::item_kind_type in_kind_ff;
   iag_pkg::item_kind_type in_kind_in;
   logic                   accept;
   logic                   push_fire;

   // The input register holds while the queue is full.
   assign req_stall = in_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push_fire = in_valid_ff && !q_full;

   // Classify the incoming item and track the input register.
   always_comb begin
      in_kind_in  = in_kind_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_kind_in  = req_restart ? iag_pkg::KIND_RESTART : iag_pkg::KIND_ADVANCE;
         in_valid_in = 1'b1;
      end else if (push_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_kind_ff <= in_kind_in;
   end

   assign push.valid = push_fire;
   assign push.kind  = in_kind_ff;

endmodule

`default_nettype wire

// ===== design/iag_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on iag_pkg for the depth and item types.
`default_nettype none

module iag_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire iag_pkg::push_type push,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output iag_pkg::item_kind_type rd_kind
);

   localparam int unsigned PTR_W = $clog2(iag_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(iag_pkg::QUEUE_DEPTH + 1);

   iag_pkg::item_kind_type slot_ff [iag_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == CNT_W'(iag_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign rd_kind = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.kind;
      end
   end

endmodule

`default_nettype wire

// ===== design/iag_back.sv =====
// Back end of the im2col address generator: walks the window counters one
// step per item and forms the source index with a shared multiply-add unit.
// Depends on iag_pkg.
`default_nettype none

module iag_back #(
   parameter int unsigned ADDR_WIDTH = 32,
   parameter int unsigned DIM_WIDTH  = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire iag_pkg::cfg_type  cfg,
   input  wire logic              q_empty,
   input  wire iag_pkg::item_kind_type q_kind,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [31:0]            rsp_src_index,
   output logic [31:0]            rsp_col_index,
   output logic                   rsp_is_pad,
   output logic                   rsp_seq_last
);

   localparam int unsigned DIM_BITS = DIM_WIDTH + 1;
   localparam int unsigned POS_BITS = DIM_WIDTH + 2;
   localparam int unsigned SAT_W    =
      (DIM_BITS > iag_pkg::DIM_CFG_W) ? DIM_BITS : iag_pkg::DIM_CFG_W;
   localparam int unsigned MUL_W    = ADDR_WIDTH + DIM_BITS;
   localparam int unsigned DIM_MAX  = 1 << DIM_WIDTH;

   // Clamp a dimension register to the largest supported extent.
   function automatic logic [DIM_BITS-1:0] sat_dim(input logic [12:0] v);
      logic [SAT_W-1:0] wide;
      wide = SAT_W'(v);
      if (wide > SAT_W'(DIM_MAX)) begin
         return DIM_BITS'(DIM_MAX);
      end
      return DIM_BITS'(wide);
   endfunction

   // Effective configuration.
   logic [DIM_BITS-1:0] h_dim, w_dim, c_dim;
   logic [8:0]          b_dim;
   logic [3:0]          k_dim, s_dim;
   logic [2:0]          p_dim;
   logic [POS_BITS-1:0] ext_h, ext_w, lim_h, lim_w;
   logic                seq_empty;

   // Walk counters.
   logic [7:0]          batch_ff, batch_in;
   logic [POS_BITS-1:0] win_row_ff, win_row_in, win_col_ff, win_col_in;
   logic [3:0]          kern_row_ff, kern_row_in, kern_col_ff, kern_col_in;
   logic [DIM_WIDTH-1:0] chan_ff, chan_in;
   logic [31:0]         col_count_ff, col_count_in;

   // Counters as seen by the current step.
   logic                stale, zero_sel;
   logic [7:0]          cur_batch;
   logic [POS_BITS-1:0] cur_wr, cur_wc;
   logic [3:0]          cur_kr, cur_kc;
   logic [DIM_WIDTH-1:0] cur_ch;
   logic [31:0]         cur_col;
   logic [POS_BITS-1:0] pos_y, pos_x;
   logic                pad, lc, lkc, lkr, lwc, lwr, lb, last;

   // Element snapshot handed to the multiply-add passes.
   logic [7:0]          snap_batch_ff;
   logic [POS_BITS-1:0] snap_yoff_ff, snap_xoff_ff;
   logic [DIM_WIDTH-1:0] snap_chan_ff;
   logic                snap_pad_ff, snap_last_ff;
   logic [31:0]         snap_col_ff;

   // Sequencer and shared multiply-add unit.
   iag_pkg::back_state_type state_ff, state_in;
   logic                step_en, acc_en, out_load, out_free;
   logic [ADDR_WIDTH-1:0] mul_a;
   logic [DIM_BITS-1:0] mul_b;
   logic [MUL_W-1:0]    mul_add;
   logic [MUL_W-1:0]    prod;
   logic [ADDR_WIDTH-1:0] acc_ff;

   // Output register.
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_src_ff, out_col_ff;
   logic                out_pad_ff, out_last_ff;

   // Effective dimensions, padded extents and window limits.
   always_comb begin
      h_dim = sat_dim(cfg.in_height);
      w_dim = sat_dim(cfg.in_width);
      c_dim = sat_dim(cfg.channels);
      b_dim = (cfg.batch_size > iag_pkg::BATCH_MAX) ? iag_pkg::BATCH_MAX : cfg.batch_size;
      k_dim = cfg.kernel_size;
      s_dim = (cfg.stride_step == 4'd0) ? 4'd1 : cfg.stride_step;
      p_dim = cfg.pad_amount;
      ext_h = POS_BITS'(h_dim) + POS_BITS'({p_dim, 1'b0});
      ext_w = POS_BITS'(w_dim) + POS_BITS'({p_dim, 1'b0});
      lim_h = ext_h - POS_BITS'(k_dim);
      lim_w = ext_w - POS_BITS'(k_dim);
      seq_empty = (h_dim == '0) || (w_dim == '0) || (c_dim == '0) || (b_dim == '0) ||
                  (k_dim == '0) || (POS_BITS'(k_dim) > ext_h) ||
                  (POS_BITS'(k_dim) > ext_w);
   end

   // Current element: restart or stale counters start from the first element.
   always_comb begin
      stale = ({1'b0, batch_ff} >= b_dim) || (win_row_ff > lim_h) ||
              (win_col_ff > lim_w) || (kern_row_ff >= k_dim) ||
              (kern_col_ff >= k_dim) || (DIM_BITS'(chan_ff) >= c_dim);
      zero_sel  = (q_kind == iag_pkg::KIND_RESTART) || stale;
      cur_batch = zero_sel ? '0 : batch_ff;
      cur_wr    = zero_sel ? '0 : win_row_ff;
      cur_wc    = zero_sel ? '0 : win_col_ff;
      cur_kr    = zero_sel ? '0 : kern_row_ff;
      cur_kc    = zero_sel ? '0 : kern_col_ff;
      cur_ch    = zero_sel ? '0 : chan_ff;
      cur_col   = zero_sel ? '0 : col_count_ff;
      pos_y     = cur_wr + POS_BITS'(cur_kr);
      pos_x     = cur_wc + POS_BITS'(cur_kc);
      pad = (pos_y < POS_BITS'(p_dim)) || (pos_x < POS_BITS'(p_dim)) ||
            (pos_y >= POS_BITS'(h_dim) + POS_BITS'(p_dim)) ||
            (pos_x >= POS_BITS'(w_dim) + POS_BITS'(p_dim));
      lc  = (DIM_BITS'(cur_ch) + DIM_BITS'(1)) >= c_dim;
      lkc = ({1'b0, cur_kc} + 5'd1) >= {1'b0, k_dim};
      lkr = ({1'b0, cur_kr} + 5'd1) >= {1'b0, k_dim};
      lwc = (cur_wc + POS_BITS'(s_dim)) > lim_w;
      lwr = (cur_wr + POS_BITS'(s_dim)) > lim_h;
      lb  = ({1'b0, cur_batch} + 9'd1) >= b_dim;
      last = lc && lkc && lkr && lwc && lwr && lb;
   end

   // Counter advance: channel innermost, batch outermost.
   always_comb begin
      batch_in     = batch_ff;
      win_row_in   = win_row_ff;
      win_col_in   = win_col_ff;
      kern_row_in  = kern_row_ff;
      kern_col_in  = kern_col_ff;
      chan_in      = chan_ff;
      col_count_in = col_count_ff;
      if (step_en) begin
         if (seq_empty || last) begin
            batch_in     = '0;
            win_row_in   = '0;
            win_col_in   = '0;
            kern_row_in  = '0;
            kern_col_in  = '0;
            chan_in      = '0;
            col_count_in = '0;
         end else begin
            batch_in     = cur_batch;
            win_row_in   = cur_wr;
            win_col_in   = cur_wc;
            kern_row_in  = cur_kr;
            kern_col_in  = cur_kc;
            col_count_in = cur_col + 32'd1;
            if (!lc) begin
               chan_in = cur_ch + DIM_WIDTH'(1);
            end else begin
               chan_in = '0;
               if (!lkc) begin
                  kern_col_in = cur_kc + 4'd1;
               end else begin
                  kern_col_in = '0;
                  if (!lkr) begin
                     kern_row_in = cur_kr + 4'd1;
                  end else begin
                     kern_row_in = '0;
                     if (!lwc) begin
                        win_col_in = cur_wc + POS_BITS'(s_dim);
                     end else begin
                        win_col_in = '0;
                        if (!lwr) begin
                           win_row_in = cur_wr + POS_BITS'(s_dim);
                        end else begin
                           win_row_in = '0;
                           batch_in   = cur_batch + 8'd1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff     <= '0;
         win_row_ff   <= '0;
         win_col_ff   <= '0;
         kern_row_ff  <= '0;
         kern_col_ff  <= '0;
         chan_ff      <= '0;
         col_count_ff <= '0;
      end else begin
         batch_ff     <= batch_in;
         win_row_ff   <= win_row_in;
         win_col_ff   <= win_col_in;
         kern_row_ff  <= kern_row_in;
         kern_col_ff  <= kern_col_in;
         chan_ff      <= chan_in;
         col_count_ff <= col_count_in;
      end
   end

   // Snapshot of the element being addressed.
   always_ff @(posedge clock) begin
      if (step_en) begin
         snap_batch_ff <= cur_batch;
         snap_yoff_ff  <= pos_y - POS_BITS'(p_dim);
         snap_xoff_ff  <= pos_x - POS_BITS'(p_dim);
         snap_chan_ff  <= cur_ch;
         snap_pad_ff   <= pad;
         snap_last_ff  <= last;
         snap_col_ff   <= cur_col;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iag_pkg::BK_IDLE: begin
            if (!q_empty && !seq_empty) begin
               state_in = iag_pkg::BK_ROW;
            end
         end
         iag_pkg::BK_ROW: state_in = iag_pkg::BK_COL;
         iag_pkg::BK_COL: state_in = iag_pkg::BK_CHAN;
         iag_pkg::BK_CHAN: begin
            if (out_free) begin
               state_in = iag_pkg::BK_IDLE;
            end
         end
         default: state_in = iag_pkg::BK_IDLE;
      endcase
   end

   // Sequencer outputs and multiply-add operand selection.
   always_comb begin
      step_en  = 1'b0;
      acc_en   = 1'b0;
      out_load = 1'b0;
      mul_a    = acc_ff;
      mul_b    = c_dim;
      mul_add  = MUL_W'(snap_chan_ff);
      case (state_ff)
         iag_pkg::BK_IDLE: begin
            step_en = !q_empty;
         end
         iag_pkg::BK_ROW: begin
            acc_en  = 1'b1;
            mul_a   = ADDR_WIDTH'(snap_batch_ff);
            mul_b   = h_dim;
            mul_add = MUL_W'(snap_yoff_ff);
         end
         iag_pkg::BK_COL: begin
            acc_en  = 1'b1;
            mul_b   = w_dim;
            mul_add = MUL_W'(snap_xoff_ff);
         end
         iag_pkg::BK_CHAN: begin
            out_load = out_free;
         end
         default: begin
            step_en = 1'b0;
         end
      endcase
   end

   assign q_pop = step_en;
   assign prod  = MUL_W'(mul_a) * MUL_W'(mul_b) + mul_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iag_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (acc_en) begin
         acc_ff <= prod[ADDR_WIDTH-1:0];
      end
   end

   // Output register: parts the sequencer from a stalled receiver.
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_src_ff  <= snap_pad_ff ? 32'd0 : 32'(prod[ADDR_WIDTH-1:0]);
         out_col_ff  <= snap_col_ff;
         out_pad_ff  <= snap_pad_ff;
         out_last_ff <= snap_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_src_index = out_src_ff;
   assign rsp_col_index = out_col_ff;
   assign rsp_is_pad    = out_pad_ff;
   assign rsp_seq_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== design/im2col_address_generator_core.sv =====
// im2col address generator for NHWC tensors. Each request item yields the
// next element of the gather walk: its NHWC source index (0 in the padding),
// its column-matrix position, a pad flag and a flag on the final element.
// A request with restart set returns the walk to its first element first.
// Request and response channels use valid/stall; an item moves at a clock
// edge with valid high and stall low. Configuration is to be written over
// the csr channel (index, data) only while the block is idle; the block
// itself does not enforce this. csr_ready is always high. The back end
// steps the walk, then makes three passes through its single multiply-add
// unit, and pops the next item only once the element is in its output
// register. When the configuration describes no element, an item is
// consumed and yields no response. A four-entry queue lets requests keep
// arriving while the back end works or the response is stalled; a stalled
// response holds in its output register. Reset is synchronous: the walk
// returns to its first element and the registers to their defaults.
// Depends on iag_pkg, iag_front, iag_queue and iag_back.
`default_nettype none

module im2col_address_generator_core #(
   parameter int unsigned ADDR_WIDTH = 32,
   parameter int unsigned DIM_WIDTH  = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_restart,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [31:0]                          rsp_src_index,
   output logic [31:0]                          rsp_col_index,
   output logic                                 rsp_is_pad,
   output logic                                 rsp_seq_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [iag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [iag_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   iag_pkg::cfg_type       cfg_ff;
   iag_pkg::cfg_type       cfg_in;
   iag_pkg::push_type      push;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   iag_pkg::item_kind_type q_kind;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            iag_pkg::CSR_IN_HEIGHT:   cfg_in.in_height   = csr_wdata[12:0];
            iag_pkg::CSR_IN_WIDTH:    cfg_in.in_width    = csr_wdata[12:0];
            iag_pkg::CSR_CHANNELS:    cfg_in.channels    = csr_wdata[12:0];
            iag_pkg::CSR_BATCH_SIZE:  cfg_in.batch_size  = csr_wdata[8:0];
            iag_pkg::CSR_KERNEL_SIZE: cfg_in.kernel_size = csr_wdata[3:0];
            iag_pkg::CSR_STRIDE_STEP: cfg_in.stride_step = csr_wdata[3:0];
            iag_pkg::CSR_PAD_AMOUNT:  cfg_in.pad_amount  = csr_wdata[2:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_height   <= iag_pkg::RST_IN_HEIGHT;
         cfg_ff.in_width    <= iag_pkg::RST_IN_WIDTH;
         cfg_ff.channels    <= iag_pkg::RST_CHANNELS;
         cfg_ff.batch_size  <= iag_pkg::RST_BATCH_SIZE;
         cfg_ff.kernel_size <= iag_pkg::RST_KERNEL_SIZE;
         cfg_ff.stride_step <= iag_pkg::RST_STRIDE_STEP;
         cfg_ff.pad_amount  <= iag_pkg::RST_PAD_AMOUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iag_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .q_full      (q_full),
      .push        (push)
   );

   iag_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_kind (q_kind)
   );

   iag_back #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DIM_WIDTH  (DIM_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_empty),
      .q_kind        (q_kind),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_src_index (rsp_src_index),
      .rsp_col_index (rsp_col_index),
      .rsp_is_pad    (rsp_is_pad),
      .rsp_seq_last  (rsp_seq_last)
   );

endmodule

`default_nettype wire
